FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the address checker modules.
// Concurrent checks on the rising clock edge, held off while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: design/eav_pkg.sv
// ----------------------------------------------------------------------------
// eav_pkg
// Types, constants and the character classifier of the address checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eav_pkg;

    localparam int CH_W         = 8;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 8;
    localparam int FIFO_DEPTH_D = 2;

    // Printable range boundaries.
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CH_DEL   = 8'd127;

    // Characters with a role of their own.
    localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CH_W-1:0] CH_AT     = 8'h40;
    localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;

    // Character class of one word, as handed from the front to the back.
    typedef struct packed {
        logic last;
        logic is_quote;
        logic is_at;
        logic is_dot;
        logic is_bslash;
        logic printable;
        logic atom_ok;
    } cls_t;

    // Parser phase, one-hot.
    typedef enum logic [5:0] {
        PH_LOCAL   = 6'b000001,
        PH_QUOTED  = 6'b000010,
        PH_QESC    = 6'b000100,
        PH_QCLOSED = 6'b001000,
        PH_DOMAIN  = 6'b010000,
        PH_FAIL    = 6'b100000
    } phase_t;

    // True for the RFC 822 specials other than the dot: ( ) < > @ , ; : \ " [ ]
    function automatic logic is_special(input logic [CH_W-1:0] ch);
        logic res;
        begin
            case (ch)
                8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C,
                8'h3B, 8'h3A, 8'h5C, 8'h22, 8'h5B, 8'h5D: res = 1'b1;
                default: res = 1'b0;
            endcase
            return res;
        end
    endfunction

    // Sort one byte into the classes the parser needs.
    function automatic cls_t classify(input logic [CH_W-1:0] ch, input logic last);
        cls_t c;
        begin
            c.last      = last;
            c.is_quote  = (ch == CH_QUOTE);
            c.is_at     = (ch == CH_AT);
            c.is_dot    = (ch == CH_DOT);
            c.is_bslash = (ch == CH_BSLASH);
            c.printable = (ch >= CH_SPACE) && (ch < CH_DEL);
            c.atom_ok   = (ch > CH_SPACE) && (ch < CH_DEL) && !is_special(ch);
            return c;
        end
    endfunction

endpackage

FILE: design/email_address_validator.sv
// ----------------------------------------------------------------------------
// email_address_validator
// Streaming RFC 822 address syntax check, one character word per clock while not stalled.
// ----------------------------------------------------------------------------
// The block takes one address byte per word on the slave side, with tlast on
// the final byte, and returns one word per address on the master side whose
// bit 0 is 1 when the address is syntactically valid. It sustains one input
// word per clock cycle while no stall holds it; after the final byte is taken
// its result word passes through the classifier register and the queue,
// after which the result register holds it. The front classifier and the
// back parser are joined by a queue of FIFO_DEPTH words, so a stall on the
// result side backs up into the queue before it stops input. No clearing
// pass is needed after reset.
`timescale 1ns / 1ps

module email_address_validator #(
    parameter int FIFO_DEPTH = eav_pkg::FIFO_DEPTH_D
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [eav_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [7:0] ch
    input  logic                            s_axis_tlast,   // last
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [eav_pkg::M_TDATA_W-1:0]   m_axis_tdata    // [0] valid_res, rest zero
);
    import eav_pkg::*;

    cls_t front_cls;
    logic front_valid;
    logic front_ready;
    cls_t queue_cls;
    logic queue_valid;
    logic queue_ready;
    logic res_bit;

    // Classify each incoming character.
    eav_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ch     (s_axis_tdata[CH_W-1:0]),
        .in_last   (s_axis_tlast),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_cls   (front_cls),
        .out_valid (front_valid),
        .out_ready (front_ready)
    );

    // Decouple the classifier from the parser.
    eav_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_cls   (front_cls),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_cls   (queue_cls),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready)
    );

    // Run the parser and hold the result word.
    eav_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_cls    (queue_cls),
        .in_valid  (queue_valid),
        .in_ready  (queue_ready),
        .res_valid (m_axis_tvalid),
        .res_bit   (res_bit),
        .res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {{(M_TDATA_W-1){1'b0}}, res_bit};

endmodule

FILE: design/eav_front.sv
// ----------------------------------------------------------------------------
// eav_front
// Input stage: takes one character word and registers its class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eav_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [eav_pkg::CH_W-1:0]    in_ch,
    input  logic                        in_last,
    input  logic                        in_valid,
    output logic                        in_ready,
    output eav_pkg::cls_t               out_cls,
    output logic                        out_valid,
    input  logic                        out_ready
);
    import eav_pkg::*;

    logic valid_reg;
    logic valid_next;
    cls_t cls_reg;

    // The stage takes a new word when empty or when its word moves on.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_cls   = cls_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Class payload needs no reset.
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            cls_reg <= classify(in_ch, in_last);
        end
    end

    // A held word keeps its class until the queue takes it.
    `ASSERT_NEXT(a_front_hold, aclk, aresetn, valid_reg && !out_ready,
                 valid_reg && $stable(cls_reg))

endmodule

FILE: design/eav_fifo.sv
// ----------------------------------------------------------------------------
// eav_fifo
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eav_fifo #(
    parameter int DEPTH = eav_pkg::FIFO_DEPTH_D
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  eav_pkg::cls_t   wr_cls,
    input  logic            wr_valid,
    output logic            wr_ready,
    output eav_pkg::cls_t   rd_cls,
    output logic            rd_valid,
    input  logic            rd_ready
);
    import eav_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cls_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_cls   = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_cls;
        end
    end

    // The fill count never passes the depth.
    `ASSERT_IMPLIES(a_fifo_count, aclk, aresetn, 1'b1, count_reg <= CNT_FULL)
    // Pointers meet exactly when the queue is empty or full.
    `ASSERT_IMPLIES(a_fifo_ptrs, aclk, aresetn, (count_reg == '0) || (count_reg == CNT_FULL),
                    wr_ptr_reg == rd_ptr_reg)

endmodule

FILE: design/eav_back.sv
// ----------------------------------------------------------------------------
// eav_back
// Parser state machine and result register of the address checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eav_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  eav_pkg::cls_t   in_cls,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            res_valid,
    output logic            res_bit,
    input  logic            res_ready
);
    import eav_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    phase_t phase_step;
    logic   at_first_reg;
    logic   at_first_next;
    logic   at_first_step;
    logic   prev_dot_reg;
    logic   prev_dot_next;
    logic   prev_dot_step;
    logic   dom_dot_reg;
    logic   dom_dot_next;
    logic   dom_dot_step;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   res_reg;
    logic   pop;

    // A word is taken when the result register is free or being drained.
    assign in_ready  = !out_valid_reg || res_ready;
    assign pop       = in_valid && in_ready;
    assign res_valid = out_valid_reg;
    assign res_bit   = res_reg;

    // One parser step on the incoming character class.
    always_comb begin
        phase_step    = phase_reg;
        at_first_step = at_first_reg;
        prev_dot_step = prev_dot_reg;
        dom_dot_step  = dom_dot_reg;
        case (phase_reg)
            PH_LOCAL: begin
                if (in_cls.is_quote && (at_first_reg || prev_dot_reg)) begin
                    phase_step    = PH_QUOTED;
                    at_first_step = 1'b0;
                    prev_dot_step = 1'b0;
                end else if (in_cls.is_at) begin
                    if (at_first_reg || prev_dot_reg) begin
                        phase_step = PH_FAIL;
                    end else begin
                        phase_step    = PH_DOMAIN;
                        at_first_step = 1'b1;
                        prev_dot_step = 1'b0;
                    end
                end else if (!in_cls.atom_ok) begin
                    phase_step = PH_FAIL;
                end else begin
                    at_first_step = 1'b0;
                    prev_dot_step = in_cls.is_dot;
                end
            end
            PH_QUOTED: begin
                if (in_cls.is_quote) begin
                    phase_step = PH_QCLOSED;
                end else if (in_cls.is_bslash) begin
                    phase_step = PH_QESC;
                end else if (!in_cls.printable) begin
                    phase_step = PH_FAIL;
                end
            end
            PH_QESC: begin
                phase_step = in_cls.printable ? PH_QUOTED : PH_FAIL;
            end
            PH_QCLOSED: begin
                if (in_cls.is_at) begin
                    phase_step    = PH_DOMAIN;
                    at_first_step = 1'b1;
                    prev_dot_step = 1'b0;
                end else if (in_cls.is_dot) begin
                    phase_step    = PH_LOCAL;
                    at_first_step = 1'b0;
                    prev_dot_step = 1'b1;
                end else begin
                    phase_step = PH_FAIL;
                end
            end
            PH_DOMAIN: begin
                // An empty label before a dot fails; a dot is an atom character.
                if (in_cls.is_dot && (at_first_reg || prev_dot_reg)) begin
                    phase_step = PH_FAIL;
                end else if (!in_cls.atom_ok) begin
                    phase_step = PH_FAIL;
                end else begin
                    at_first_step = 1'b0;
                    prev_dot_step = in_cls.is_dot;
                    dom_dot_step  = dom_dot_reg || in_cls.is_dot;
                end
            end
            default: begin
                phase_step = PH_FAIL;
            end
        endcase
    end

    // Commit the step, and on the final word form the result and clear.
    always_comb begin
        phase_next     = phase_reg;
        at_first_next  = at_first_reg;
        prev_dot_next  = prev_dot_reg;
        dom_dot_next   = dom_dot_reg;
        out_valid_next = out_valid_reg && !res_ready;
        if (pop) begin
            if (in_cls.last) begin
                phase_next     = PH_LOCAL;
                at_first_next  = 1'b1;
                prev_dot_next  = 1'b0;
                dom_dot_next   = 1'b0;
                out_valid_next = 1'b1;
            end else begin
                phase_next    = phase_step;
                at_first_next = at_first_step;
                prev_dot_next = prev_dot_step;
                dom_dot_next  = dom_dot_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_LOCAL;
            at_first_reg  <= 1'b1;
            prev_dot_reg  <= 1'b0;
            dom_dot_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            at_first_reg  <= at_first_next;
            prev_dot_reg  <= prev_dot_next;
            dom_dot_reg   <= dom_dot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        if (pop && in_cls.last) begin
            res_reg <= (phase_step == PH_DOMAIN) && !at_first_step && dom_dot_step;
        end
    end

    // A final word always produces a result next cycle.
    `ASSERT_NEXT(a_back_result, aclk, aresetn, pop && in_cls.last, out_valid_reg)
    // After a final word the parser starts over in the local part.
    `ASSERT_NEXT(a_back_clear, aclk, aresetn, pop && in_cls.last,
                 (phase_reg == PH_LOCAL) && at_first_reg && !dom_dot_reg)

endmodule
